// File: src/vn_pkg.sv
`default_nettype none
package vn_pkg;
    localparam int IN_WIDTH_DEF  = 24;
    localparam int FRAC_BITS_DEF = 14;
    localparam int OUT_WIDTH     = 16;
    localparam int NUM_LANES     = 3;
    // front-end stages: square stage plus sum stage
    localparam int FRONT_STAGES  = 2;

    typedef logic [OUT_WIDTH-1:0] t_unit;
endpackage
`default_nettype wire

// File: src/vn_front.sv
`default_nettype none
// Magnitudes, squares and sum of squares, two register stages.
module vn_front #(
    parameter int IN_WIDTH = vn_pkg::IN_WIDTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  wire [IN_WIDTH-1:0]    i_comp [vn_pkg::NUM_LANES],
    output logic [2*IN_WIDTH-1:0] o_sq   [vn_pkg::NUM_LANES],
    output logic                  o_neg  [vn_pkg::NUM_LANES],
    output logic [2*IN_WIDTH+1:0] o_sum,
    output logic                  o_zero
);
    localparam int NL = vn_pkg::NUM_LANES;
    localparam int SQW = 2 * IN_WIDTH;
    localparam int SW = SQW + 2;

    logic [SQW-1:0] r_sq_a [NL];
    logic           r_neg_a [NL];
    logic           r_zero_a;
    logic [SQW-1:0] r_sq_b [NL];
    logic           r_neg_b [NL];
    logic [SW-1:0]  r_sum;
    logic           r_zero_b;
    logic [IN_WIDTH-1:0] mag [NL];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            // most negative value maps to 2^(IN_WIDTH-1), fits unsigned
            mag[i] = i_comp[i][IN_WIDTH-1] ? (~i_comp[i] + IN_WIDTH'(1)) : i_comp[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NL; i++) begin
                r_sq_a[i]  <= SQW'(mag[i]) * SQW'(mag[i]);
                r_neg_a[i] <= i_comp[i][IN_WIDTH-1];
                r_sq_b[i]  <= r_sq_a[i];
                r_neg_b[i] <= r_neg_a[i];
            end
            r_zero_a <= (i_comp[0] == '0) && (i_comp[1] == '0) && (i_comp[2] == '0);
            r_sum    <= SW'(r_sq_a[0]) + SW'(r_sq_a[1]) + SW'(r_sq_a[2]);
            r_zero_b <= r_zero_a;
        end
    end

    assign o_sq   = r_sq_b;
    assign o_neg  = r_neg_b;
    assign o_sum  = r_sum;
    assign o_zero = r_zero_b;
endmodule
`default_nettype wire

// File: src/vn_lane.sv
`default_nettype none
// One component: largest q <= 2^F with q^2*S <= m^2*2^(2F), one bit per stage.
// Keeps R = q*S and D = m^2*2^(2F) - q^2*S so each stage is shift-add-compare.
module vn_lane #(
    parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  wire [2*IN_WIDTH-1:0]  i_sq,
    input  wire [2*IN_WIDTH+1:0]  i_sum,
    input  wire                   i_neg,
    output logic [FRAC_BITS:0]    o_q,
    output logic                  o_neg
);
    localparam int F  = FRAC_BITS;
    localparam int QW = F + 1;
    localparam int SW = 2 * IN_WIDTH + 2;
    localparam int RW = SW + F + 1;
    localparam int WT = 2 * IN_WIDTH + 2 * F + 4;

    logic [QW-1:0] r_q   [0:F];
    logic          r_neg [0:F];
    logic [RW-1:0] r_r   [0:F-1];
    logic [WT-1:0] r_d   [0:F-1];
    logic [SW-1:0] r_s   [0:F-1];

    for (genvar k = 0; k <= F; k++) begin : g_stage
        localparam int B = F - k;
        logic [QW-1:0] q_in;
        logic [RW-1:0] r_in;
        logic [WT-1:0] d_in;
        logic [SW-1:0] s_in;
        logic          neg_in;
        logic [WT-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign q_in   = '0;
            assign r_in   = '0;
            assign d_in   = WT'(i_sq) << (2 * F);
            assign s_in   = i_sum;
            assign neg_in = i_neg;
        end else begin : g_next
            assign q_in   = r_q[k-1];
            assign r_in   = r_r[k-1];
            assign d_in   = r_d[k-1];
            assign s_in   = r_s[k-1];
            assign neg_in = r_neg[k-1];
        end

        // (q+2^B)^2*S - q^2*S = 2^(B+1)*R + 2^(2B)*S
        assign trial = (WT'(r_in) << (B + 1)) + (WT'(s_in) << (2 * B));
        assign take  = (trial <= d_in);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= take ? (q_in | (QW'(1) << B)) : q_in;
                r_neg[k] <= neg_in;
            end
        end

        if (k < F) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[k] <= take ? (r_in + (RW'(s_in) << B)) : r_in;
                    r_d[k] <= take ? (d_in - trial) : d_in;
                    r_s[k] <= s_in;
                end
            end
        end
    end

    assign o_q   = r_q[F];
    assign o_neg = r_neg[F];
endmodule
`default_nettype wire

// File: src/vector_normalize_3d_core.sv
`default_nettype none
// 3D vector normalization, signed Q2.14 unit vector, rounded toward zero.
//
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  input     | i_valid, o_stall, i_comp_x/y/z            | in
//  output    | o_valid, i_stall, o_unit_x/y/z, o_zero_length | out
//
// Throughput: one beat per cycle while the output is not stalled. Pipeline:
// square, sum, FRAC_BITS+1 root-divide stages, output register.
// Each lane resolves one quotient bit per stage with a shift-add-compare.
// Reset clears the valid pipeline only; payload registers are not reset.
// A stalled output beat freezes the whole pipeline; input is stalled
// only while a held output beat is stalled.
module vector_normalize_3d_core #(
    parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire signed [IN_WIDTH-1:0]  i_comp_x,
    input  wire signed [IN_WIDTH-1:0]  i_comp_y,
    input  wire signed [IN_WIDTH-1:0]  i_comp_z,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic signed [vn_pkg::OUT_WIDTH-1:0] o_unit_x,
    output logic signed [vn_pkg::OUT_WIDTH-1:0] o_unit_y,
    output logic signed [vn_pkg::OUT_WIDTH-1:0] o_unit_z,
    output logic                       o_zero_length
);
    localparam int NL  = vn_pkg::NUM_LANES;
    localparam int OW  = vn_pkg::OUT_WIDTH;
    localparam int QW  = FRAC_BITS + 1;
    localparam int LAT = vn_pkg::FRONT_STAGES + FRAC_BITS + 1;

    logic                  en;
    logic [IN_WIDTH-1:0]   comp [NL];
    logic [2*IN_WIDTH-1:0] sq   [NL];
    logic                  neg  [NL];
    logic [2*IN_WIDTH+1:0] sum;
    logic                  zero_f;
    logic [QW-1:0]         q    [NL];
    logic                  q_neg [NL];

    logic [LAT-1:0]        r_vld;      // beat valid per stage
    logic [FRAC_BITS:0]    r_zero;     // zero flag alongside the lanes
    logic                  r_out_vld;
    vn_pkg::t_unit         r_unit [NL];
    logic                  r_out_zero;
    vn_pkg::t_unit         n_unit [NL];

    // whole pipeline moves unless the held output beat is stalled
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;

    assign comp[0] = i_comp_x;
    assign comp[1] = i_comp_y;
    assign comp[2] = i_comp_z;

    vn_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_comp (comp),
        .o_sq   (sq),
        .o_neg  (neg),
        .o_sum  (sum),
        .o_zero (zero_f)
    );

    for (genvar i = 0; i < NL; i++) begin : g_lane
        vn_lane #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sq  (sq[i]),
            .i_sum (sum),
            .i_neg (neg[i]),
            .o_q   (q[i]),
            .o_neg (q_neg[i])
        );
    end

    // merge: apply signs, truncate to the output width, force zero vector
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (r_zero[FRAC_BITS]) begin
                n_unit[i] = '0;
            end else if (q_neg[i]) begin
                n_unit[i] = OW'(~(64'(q[i])) + 64'd1);
            end else begin
                n_unit[i] = OW'(64'(q[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[LAT-2:0], i_valid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero     <= {r_zero[FRAC_BITS-1:0], zero_f};
            r_unit     <= n_unit;
            r_out_zero <= r_zero[FRAC_BITS];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];
    assign o_zero_length = r_out_zero;

    // a zero-length beat carries an all-zero vector
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |-> (o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0))
        else $error("zero-length beat with nonzero unit vector");

    // input stall only while an output beat is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output beat");

    // a beat in the last lane stage reaches the output after an open cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && en) |=> o_valid)
        else $error("beat lost between lanes and output");

    // no output beat right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

// File: dv/vector_normalize_3d_core_test.sv
`default_nettype none
module vector_normalize_3d_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = vn_pkg::IN_WIDTH_DEF;
    localparam int FB = vn_pkg::FRAC_BITS_DEF;
    localparam int OW = vn_pkg::OUT_WIDTH;
    // pipeline depth from the core header: square, sum, FB+1 divide, output reg
    localparam int LATENCY = FB + 4;

    typedef struct packed {
        logic [OW-1:0] ux;
        logic [OW-1:0] uy;
        logic [OW-1:0] uz;
        logic          zl;
    } unit_vec_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [IW-1:0] i_comp_x;
    logic signed [IW-1:0] i_comp_y;
    logic signed [IW-1:0] i_comp_z;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [OW-1:0] o_unit_x;
    logic signed [OW-1:0] o_unit_y;
    logic signed [OW-1:0] o_unit_z;
    logic                 o_zero_length;

    vector_normalize_3d_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_comp_x      (i_comp_x),
        .i_comp_y      (i_comp_y),
        .i_comp_z      (i_comp_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_unit_x      (o_unit_x),
        .o_unit_y      (o_unit_y),
        .o_unit_z      (o_unit_z),
        .o_zero_length (o_zero_length)
    );

    // expected unit vectors, oldest first
    unit_vec_t expected_units[$];
    int        errors;
    int        send_idle_pct;   // chance in 100 that the sender skips a cycle
    int        recv_stall_pct;  // chance in 100 that the receiver stalls

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // largest q <= 2^FB with q*q*sum <= mag*mag*2^(2*FB); bit-serial search
    function automatic logic [FB:0] unit_magnitude(logic [IW:0] mag, logic [2*IW+2:0] sum);
        logic [FB:0]         q;
        logic [FB:0]         t;
        logic [2*FB+2*IW+8:0] rhs;
        logic [2*FB+2*IW+8:0] lhs;
        q = '0;
        rhs = ({{(2*FB+IW+8){1'b0}}, mag} * mag) << (2 * FB);
        for (int b = FB; b >= 0; b--) begin
            t = q | ((FB+1)'(1) << b);
            lhs = {{(2*FB+2*IW+8-FB){1'b0}}, t} * t * sum;
            if (lhs <= rhs) q = t;
        end
        return q;
    endfunction

    function automatic unit_vec_t normalize(logic signed [IW-1:0] x, logic signed [IW-1:0] y,
                                            logic signed [IW-1:0] z);
        logic [IW:0]     mag[3];
        logic            neg[3];
        logic [2*IW+2:0] sum;
        logic [FB:0]     q;
        logic [OW-1:0]   u[3];
        unit_vec_t       r;
        logic signed [IW-1:0] c[3];
        c[0] = x; c[1] = y; c[2] = z;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i][IW-1];
            // sign-extend first so the most negative value keeps its full magnitude
            mag[i] = neg[i] ? -{c[i][IW-1], c[i]} : {1'b0, c[i]};
            sum += (2*IW+3)'(mag[i]) * mag[i];
        end
        if (sum == 0) begin
            r = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
        end else begin
            for (int i = 0; i < 3; i++) begin
                q = unit_magnitude(mag[i], sum);
                u[i] = neg[i] ? OW'(-(OW+1)'(q)) : OW'(q);
            end
            r = '{ux: u[0], uy: u[1], uz: u[2], zl: 1'b0};
        end
        return r;
    endfunction

    // one beat: optional random idle, then hold valid until accepted
    task automatic send_vector(logic signed [IW-1:0] x, logic signed [IW-1:0] y,
                               logic signed [IW-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        expected_units.push_back(normalize(x, y, z));
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker: compare each accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        unit_vec_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected beat x=%h y=%h z=%h zl=%b", $time,
                         o_unit_x, o_unit_y, o_unit_z, o_zero_length);
                errors++;
            end else begin
                want = expected_units.pop_front();
                if (want !== {o_unit_x, o_unit_y, o_unit_z, o_zero_length}) begin
                    $display("%0t: mismatch exp x=%h y=%h z=%h zl=%b act x=%h y=%h z=%h zl=%b",
                             $time, want.ux, want.uy, want.uz, want.zl,
                             o_unit_x, o_unit_y, o_unit_z, o_zero_length);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [IW-1:0] pick_component();
        case ($urandom_range(5))
            0: return '0;
            1: return {1'b1, {(IW-1){1'b0}}};
            2: return {1'b0, {(IW-1){1'b1}}};
            3: return IW'($signed($urandom_range(32)) - 16);
            default: return IW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        localparam logic signed [IW-1:0] MAXP = {1'b0, {(IW-1){1'b1}}};
        localparam logic signed [IW-1:0] MAXN = {1'b1, {(IW-1){1'b0}}};
        send_vector(0, 0, 0);          // zero vector
        send_vector(1, 0, 0);          // axis aligned
        send_vector(0, -1, 0);
        send_vector(0, 0, MAXN);       // most negative component alone
        send_vector(MAXP, 0, 0);
        send_vector(MAXN, MAXN, MAXN);
        send_vector(MAXP, MAXP, MAXP);
        send_vector(MAXN, MAXP, 0);
        send_vector(-1, -1, -1);
        send_vector(1, 1, 1);
        send_vector(3, 4, 0);
        send_vector(1, 2, 2);
        send_vector(-2, 3, -6);
        send_vector(MAXN, 1, -1);
        send_vector(1, MAXP, 0);
        send_vector(-1, 0, MAXN);
        send_vector(IW'(24'h555555), IW'(24'haaaaaa), IW'(24'h0f0f0f));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_vector(pick_component(), pick_component(), pick_component());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_stall  <= 1'b0;
        i_comp_x <= '0;
        i_comp_y <= '0;
        i_comp_z <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 25; recv_stall_pct = 65;
        test_directed();
        test_random(600);
        send_idle_pct = 65; recv_stall_pct = 25;
        test_random(600);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(630);
        drain();

        if (errors == 0 && expected_units.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
src/vn_pkg.sv
src/vn_front.sv
src/vn_lane.sv
src/vector_normalize_3d_core.sv
dv/vector_normalize_3d_core_test.sv
